### rtl/amdfs_pkg.sv
// Shared types and constants for the adjacency-matrix depth-first search engine.
// No dependencies; the engine core imports this package.
package amdfs_pkg;

  localparam int NODE_W   = 6;
  localparam int WEIGHT_W = 16;
  localparam int VNODE_W  = 4;
  localparam int EDGE_W   = 9;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_DFS   = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [NODE_W-1:0]          src_node;
    logic [NODE_W-1:0]          dest_node;
    logic signed [WEIGHT_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [VNODE_W-1:0] visited_node;
    logic               last;
    logic               status;
    logic [EDGE_W-1:0]  edge_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_CHECK,
    ST_SCAN,
    ST_POP_RD,
    ST_POP_CHK
  } state_e;

endpackage

### rtl/adjacency_matrix_dfs_engine_core.sv
// Weighted adjacency matrix with edge count and stack-based depth-first traversal.
// Results: a write gives its result through the write-check state and the result
// register; a bad index gives it from the result register straight out of idle.
// Traversal: each visited vertex has one matrix row scanned through the single
// read port of the matrix RAM, and each stale stack entry costs a pop read and a
// pop check. One item at a time; busy stays high until the last result is registered.
// Reset: asynchronous, clears control state, then sweeps the matrix to zero.
module adjacency_matrix_dfs_engine_core
  import amdfs_pkg::*;
#(
  parameter int VERTICES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  in_item_t            item_i,
  output logic                result_valid_o,
  output out_item_t           result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [WEIGHT_W-1:0] cfg_data_i
);

  localparam int IW    = $clog2(VERTICES);
  localparam int DEPTH = VERTICES * VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(DEPTH + 1);

  localparam logic [AW-1:0]     ROW_LEN   = AW'(VERTICES);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [IW:0]       SCAN_END  = (IW + 1)'(VERTICES);
  localparam logic [SW-1:0]     STK_DEPTH = SW'(DEPTH);
  localparam logic [NODE_W:0]   NODE_LIM  = (NODE_W + 1)'(VERTICES);
  localparam logic [EDGE_W-1:0] EDGE_MAX  = '1;

  state_e               state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [IW-1:0]        cur_q, cur_d;
  logic [IW-1:0]        pend_q, pend_d;
  logic [IW:0]          scan_q, scan_d;
  logic [SW-1:0]        top_q, top_d;
  logic [VERTICES-1:0]  visited_q, visited_d;
  logic [EDGE_W-1:0]    edge_q, edge_d;
  logic [WEIGHT_W-1:0]  dflt_q;
  logic [AW-1:0]        wr_addr_q, wr_addr_d;
  logic [WEIGHT_W-1:0]  wr_data_q, wr_data_d;
  logic                 res_valid_q, res_valid_d;
  out_item_t            res_q, res_d;

  logic                 mat_we, mat_re;
  logic [AW-1:0]        mat_waddr, mat_raddr;
  logic [WEIGHT_W-1:0]  mat_wdata, mat_rdata;
  logic                 stk_we, stk_re;
  logic [AW-1:0]        stk_waddr, stk_raddr;
  logic [IW-1:0]        stk_wdata, stk_rdata;

  logic                 src_bad, dst_bad;
  logic [AW-1:0]        req_addr;
  logic [IW-1:0]        chk_node;
  logic [SW-1:0]        top_dec;
  logic                 prev_dflt, new_dflt;

  assign src_bad   = {1'b0, item_i.src_node} >= NODE_LIM;
  assign dst_bad   = {1'b0, item_i.dest_node} >= NODE_LIM;
  assign req_addr  = AW'(item_i.src_node[IW-1:0]) * ROW_LEN + AW'(item_i.dest_node[IW-1:0]);
  assign chk_node  = IW'(scan_q - (IW + 1)'(1));
  assign top_dec   = top_q - SW'(1);
  assign prev_dflt = (mat_rdata == dflt_q);
  assign new_dflt  = (wr_data_q == dflt_q);

  amdfs_ram #(.WIDTH(WEIGHT_W), .DEPTH(DEPTH)) u_matrix (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (mat_wdata),
    .re_i    (mat_re),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  amdfs_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      pend_q      <= '0;
      scan_q      <= '0;
      top_q       <= '0;
      visited_q   <= '0;
      edge_q      <= '0;
      dflt_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      pend_q      <= pend_d;
      scan_q      <= scan_d;
      top_q       <= top_d;
      visited_q   <= visited_d;
      edge_q      <= edge_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        dflt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    wr_data_q <= wr_data_d;
    res_q     <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    scan_d      = scan_q;
    top_d       = top_q;
    visited_d   = visited_q;
    edge_d      = edge_q;
    wr_addr_d   = wr_addr_q;
    wr_data_d   = wr_data_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mat_we      = 1'b0;
    mat_waddr   = clr_q;
    mat_wdata   = '0;
    mat_re      = 1'b0;
    mat_raddr   = req_addr;
    stk_we      = 1'b0;
    stk_waddr   = top_q[AW-1:0];
    stk_wdata   = chk_node;
    stk_re      = 1'b0;
    stk_raddr   = top_dec[AW-1:0];

    case (state_q)
      ST_CLEAR: begin
        mat_we = 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (item_i.mode == MODE_WRITE) begin
            if (src_bad || dst_bad) begin
              res_valid_d = 1'b1;
              res_d       = '{visited_node: '0, last: 1'b1, status: STATUS_BAD,
                              edge_count: edge_q};
            end else begin
              mat_re    = 1'b1;
              wr_addr_d = req_addr;
              wr_data_d = item_i.weight;
              state_d   = ST_WR_CHECK;
            end
          end else if (src_bad) begin
            res_valid_d = 1'b1;
            res_d       = '{visited_node: '0, last: 1'b1, status: STATUS_BAD,
                            edge_count: edge_q};
          end else begin
            // The start vertex is popped at once: mark it and scan its row.
            visited_d = '0;
            visited_d[item_i.src_node[IW-1:0]] = 1'b1;
            cur_d   = item_i.src_node[IW-1:0];
            pend_d  = item_i.src_node[IW-1:0];
            top_d   = '0;
            scan_d  = '0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_WR_CHECK: begin
        mat_we    = 1'b1;
        mat_waddr = wr_addr_q;
        mat_wdata = wr_data_q;
        if (prev_dflt && !new_dflt && edge_q != EDGE_MAX) begin
          edge_d = edge_q + EDGE_W'(1);
        end else if (!prev_dflt && new_dflt && edge_q != '0) begin
          edge_d = edge_q - EDGE_W'(1);
        end
        res_valid_d = 1'b1;
        res_d       = '{visited_node: '0, last: 1'b1, status: STATUS_OK,
                        edge_count: edge_d};
        state_d     = ST_IDLE;
      end

      ST_SCAN: begin
        // Issue the read of column scan_q, check the column whose read was issued in the previous cycle.
        if (scan_q < SCAN_END) begin
          mat_re    = 1'b1;
          mat_raddr = AW'(cur_q) * ROW_LEN + AW'(scan_q[IW-1:0]);
        end
        if (scan_q != '0) begin
          if (mat_rdata != dflt_q && !visited_q[chk_node] && top_q < STK_DEPTH) begin
            stk_we = 1'b1;
            top_d  = top_q + SW'(1);
          end
        end
        if (scan_q == SCAN_END) begin
          state_d = ST_POP_RD;
        end else begin
          scan_d = scan_q + (IW + 1)'(1);
        end
      end

      ST_POP_RD: begin
        if (top_q == '0) begin
          res_valid_d = 1'b1;
          res_d       = '{visited_node: VNODE_W'(pend_q), last: 1'b1, status: STATUS_OK,
                          edge_count: edge_q};
          state_d     = ST_IDLE;
        end else begin
          stk_re  = 1'b1;
          top_d   = top_dec;
          state_d = ST_POP_CHK;
        end
      end

      ST_POP_CHK: begin
        if (visited_q[stk_rdata]) begin
          state_d = ST_POP_RD;
        end else begin
          // A new visit proves the held vertex was not the final one.
          visited_d[stk_rdata] = 1'b1;
          res_valid_d = 1'b1;
          res_d       = '{visited_node: VNODE_W'(pend_q), last: 1'b0, status: STATUS_OK,
                          edge_count: edge_q};
          pend_d  = stk_rdata;
          cur_d   = stk_rdata;
          scan_d  = '0;
          state_d = ST_SCAN;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= STK_DEPTH)
    else $error("stack pointer beyond stack depth");

  a_scan_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> visited_q[cur_q])
    else $error("scanning a row of an unvisited vertex");

  a_wr_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WR_CHECK |=> res_valid_q && res_q.last)
    else $error("write check gave no final result");

  a_edge_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_WR_CHECK |=> $stable(edge_q))
    else $error("edge count changed outside a write");

  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status == STATUS_BAD |-> res_q.last && res_q.visited_node == '0)
    else $error("invalid-index result not final");

endmodule

### rtl/amdfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module amdfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
